/* src/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("%m: implication failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

/* src/dhfk_pkg.sv */
// Constants, types and fixed-point helpers of the forward kinematics block.
package dhfk_pkg;

   localparam int MAX_LINKS   = 4;
   localparam int TRIG_STAGES = 16;
   localparam int LINK_WORDS  = 4;
   localparam int NLANE       = 2 * MAX_LINKS;     // joint angles, then twists
   localparam int CW          = 34;                // CORDIC datapath width
   localparam int AT_DEPTH    = 2 * MAX_LINKS - 1; // link matrix delay line
   localparam int PT_DEPTH    = TRIG_STAGES + 4 + 2 * MAX_LINKS;
   localparam int LATENCY     = TRIG_STAGES + 6 + 2 * MAX_LINKS;

   localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic signed [15:0]   ONE_Q14   = 16'sd16384;
   localparam logic signed [47:0]   POS_MAX   = 48'sd8388607;
   localparam logic signed [47:0]   POS_MIN   = -48'sd8388608;

   typedef enum logic [2:0] {
      CSR_LINK_0,
      CSR_LINK_1,
      CSR_LINK_2,
      CSR_LINK_3,
      CSR_LINKS_IN_USE
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } point_type;

   // round half up from Q14 products
   function automatic logic signed [47:0] rnd14(input logic signed [47:0] v);
      return (v + 48'sd8192) >>> 14;
   endfunction

   function automatic logic signed [15:0] clamp_rot(input logic signed [47:0] v);
      logic signed [15:0] r;
      if (v > 48'sd16384) r = ONE_Q14;
      else if (v < -48'sd16384) r = -ONE_Q14;
      else r = 16'(v);
      return r;
   endfunction

   function automatic logic signed [23:0] sat_pos(input logic signed [47:0] v);
      logic signed [23:0] r;
      if (v > POS_MAX) r = 24'(POS_MAX);
      else if (v < POS_MIN) r = 24'(POS_MIN);
      else r = 24'(v);
      return r;
   endfunction

   // arctangent of 2^-i, 2^32 units per turn
   function automatic logic signed [CW-1:0] atan_val(input logic [4:0] i);
      logic signed [CW-1:0] r;
      unique case (i)
         5'd0:  r = 34'sh020000000;
         5'd1:  r = 34'sh012E4051E;
         5'd2:  r = 34'sh009FB385B;
         5'd3:  r = 34'sh0051111D4;
         5'd4:  r = 34'sh0028B0D43;
         5'd5:  r = 34'sh00145D7E1;
         5'd6:  r = 34'sh000A2F61E;
         5'd7:  r = 34'sh000517C55;
         5'd8:  r = 34'sh00028BE53;
         5'd9:  r = 34'sh000145F2F;
         5'd10: r = 34'sh0000A2F98;
         5'd11: r = 34'sh0000517CC;
         5'd12: r = 34'sh000028BE6;
         5'd13: r = 34'sh0000145F3;
         5'd14: r = 34'sh00000A2FA;
         5'd15: r = 34'sh00000517D;
         5'd16: r = 34'sh0000028BE;
         5'd17: r = 34'sh00000145F;
         5'd18: r = 34'sh000000A30;
         5'd19: r = 34'sh000000518;
         5'd20: r = 34'sh00000028C;
         5'd21: r = 34'sh000000146;
         5'd22: r = 34'sh0000000A3;
         5'd23: r = 34'sh000000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* src/dh_forward_kinematics_top.sv */
// Pipelined Denavit-Hartenberg forward kinematics for up to four revolute joints.
//
// Usage:
//   A pose transfer is taken at each clock edge with start high; busy stays
//   low, so one pose can enter in every cycle.
//   Each result appears on the rsp_ ports for one cycle with rsp_strobe high.
//   Throughput is one pose per cycle.
//   Latency is set by the CORDIC lanes (one iteration per stage, eight lanes
//   for joint angles and twists), two stages to build each link matrix, two
//   stages per chained link (multiply, then sum and round) and two stages
//   for the point transform.
//   The receiver cannot stall: results leave in order on the strobe.
//   Link words and the link count are written on the csr_ channel, which is
//   always ready; write them only while no pose is in flight.
//   Synchronous reset clears all valid bits, zeroes the link words and sets
//   the link count to four. No clearing pass is needed.
`include "assert_macros.svh"

module dh_forward_kinematics_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_joint_angle_0,
   input  logic signed [15:0] req_joint_angle_1,
   input  logic signed [15:0] req_joint_angle_2,
   input  logic signed [15:0] req_joint_angle_3,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_point_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_rot_00,
   output logic signed [15:0] rsp_rot_01,
   output logic signed [15:0] rsp_rot_02,
   output logic signed [15:0] rsp_rot_10,
   output logic signed [15:0] rsp_rot_11,
   output logic signed [15:0] rsp_rot_12,
   output logic signed [15:0] rsp_rot_20,
   output logic signed [15:0] rsp_rot_21,
   output logic signed [15:0] rsp_rot_22,
   output logic signed [23:0] rsp_base_x,
   output logic signed [23:0] rsp_base_y,
   output logic signed [23:0] rsp_base_z
);

   localparam int M  = dhfk_pkg::MAX_LINKS;
   localparam int TS = dhfk_pkg::TRIG_STAGES;
   localparam int NL = dhfk_pkg::NLANE;
   localparam int CW = dhfk_pkg::CW;
   localparam logic signed [15:0] ONE = dhfk_pkg::ONE_Q14;

   // configuration
   logic [47:0] link_ff [dhfk_pkg::LINK_WORDS];
   logic [2:0]  lcnt_ff;
   logic [2:0]  cnt_eff;
   logic        act [M];

   // valid line and point delay line
   logic                vld_ff [dhfk_pkg::LATENCY];
   dhfk_pkg::point_type pt_ff  [dhfk_pkg::PT_DEPTH];

   // CORDIC lanes
   logic signed [CW-1:0] cx_ff [TS+1][NL];
   logic signed [CW-1:0] cy_ff [TS+1][NL];
   logic signed [CW-1:0] cz_ff [TS+1][NL];
   logic                 cf_ff [TS+1][NL];
   logic signed [15:0]   tc_ff [NL];
   logic signed [15:0]   ts_ff [NL];
   logic signed [15:0]   ang   [NL];

   // link matrix build
   logic signed [15:0] ct_ff [M];
   logic signed [15:0] st_ff [M];
   logic signed [15:0] ca_ff [M];
   logic signed [15:0] sa_ff [M];
   logic signed [31:0] sc_ff [M];
   logic signed [31:0] ss_ff [M];
   logic signed [31:0] cc_ff [M];
   logic signed [31:0] cs_ff [M];
   logic signed [31:0] ac_ff [M];
   logic signed [31:0] as_ff [M];
   logic signed [15:0] at_ff [dhfk_pkg::AT_DEPTH][M][3][3];
   logic signed [16:0] tt_ff [dhfk_pkg::AT_DEPTH][M][2];

   // chain
   logic signed [15:0] rin   [M][3][3];
   logic signed [23:0] pin   [M][3];
   logic signed [16:0] tv    [M][3];
   logic signed [31:0] mr_ff [M][3][3][3];
   logic signed [33:0] mp_ff [M][3][3];
   logic signed [15:0] ri_ff [M][3][3];
   logic signed [23:0] pi_ff [M][3];
   logic signed [15:0] rr_ff [M][3][3];
   logic signed [23:0] pp_ff [M][3];

   // point transform and output
   logic signed [31:0] fm_ff   [3][3];
   logic signed [15:0] fr_ff   [3][3];
   logic signed [23:0] fp_ff   [3];
   logic signed [15:0] rot_ff  [3][3];
   logic signed [23:0] base_ff [3];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dhfk_pkg::LINK_WORDS; i++) link_ff[i] <= '0;
         lcnt_ff <= 3'd4;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dhfk_pkg::CSR_LINK_0, dhfk_pkg::CSR_LINK_1,
            dhfk_pkg::CSR_LINK_2, dhfk_pkg::CSR_LINK_3: begin
               link_ff[csr_index[1:0]] <= csr_data;
            end
            dhfk_pkg::CSR_LINKS_IN_USE: begin
               lcnt_ff <= csr_data[2:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cnt_eff = (lcnt_ff > 3'(M)) ? 3'(M) : lcnt_ff;

   always_comb begin
      for (int k = 0; k < M; k++) act[k] = (cnt_eff > 3'(k));
   end

   // valid bits travel with the pose
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dhfk_pkg::LATENCY; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= start && !busy;
         for (int i = 1; i < dhfk_pkg::LATENCY; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      pt_ff[0] <= '{x: req_point_x, y: req_point_y, z: req_point_z};
      for (int i = 1; i < dhfk_pkg::PT_DEPTH; i++) pt_ff[i] <= pt_ff[i-1];
   end

   // lane angles: joints first, twists after
   always_comb begin
      logic signed [15:0] jang [M];
      jang[0] = req_joint_angle_0;
      jang[1] = req_joint_angle_1;
      jang[2] = req_joint_angle_2;
      jang[3] = req_joint_angle_3;
      for (int k = 0; k < M; k++) begin
         ang[k]   = jang[k];
         ang[M+k] = $signed(link_ff[k][47:32]);
      end
   end

   // CORDIC entry: fold into [-90, 90) degrees, then one iteration per stage
   always_ff @(posedge clock) begin
      logic [31:0] zu;
      logic [31:0] zq;
      logic        fl;
      for (int l = 0; l < NL; l++) begin
         zu = {ang[l], 16'h0000};
         zq = zu + 32'h4000_0000;
         fl = zq[31];
         cf_ff[0][l] <= fl;
         cx_ff[0][l] <= dhfk_pkg::CORDIC_X0;
         cy_ff[0][l] <= '0;
         cz_ff[0][l] <= CW'($signed(fl ? zu + 32'h8000_0000 : zu));
      end
      for (int s = 0; s < TS; s++) begin
         for (int l = 0; l < NL; l++) begin
            cf_ff[s+1][l] <= cf_ff[s][l];
            if (!cz_ff[s][l][CW-1]) begin
               cx_ff[s+1][l] <= cx_ff[s][l] - (cy_ff[s][l] >>> s);
               cy_ff[s+1][l] <= cy_ff[s][l] + (cx_ff[s][l] >>> s);
               cz_ff[s+1][l] <= cz_ff[s][l] - dhfk_pkg::atan_val(5'(s));
            end else begin
               cx_ff[s+1][l] <= cx_ff[s][l] + (cy_ff[s][l] >>> s);
               cy_ff[s+1][l] <= cy_ff[s][l] - (cx_ff[s][l] >>> s);
               cz_ff[s+1][l] <= cz_ff[s][l] + dhfk_pkg::atan_val(5'(s));
            end
         end
      end
   end

   // Q30 to Q2.14, undo the half-turn fold
   always_ff @(posedge clock) begin
      logic signed [15:0] xc;
      logic signed [15:0] yc;
      for (int l = 0; l < NL; l++) begin
         xc = dhfk_pkg::clamp_rot((48'(cx_ff[TS][l]) + 48'sd32768) >>> 16);
         yc = dhfk_pkg::clamp_rot((48'(cy_ff[TS][l]) + 48'sd32768) >>> 16);
         tc_ff[l] <= cf_ff[TS][l] ? -xc : xc;
         ts_ff[l] <= cf_ff[TS][l] ? -yc : yc;
      end
   end

   // link products
   always_ff @(posedge clock) begin
      for (int k = 0; k < M; k++) begin
         ct_ff[k] <= tc_ff[k];
         st_ff[k] <= ts_ff[k];
         ca_ff[k] <= tc_ff[M+k];
         sa_ff[k] <= ts_ff[M+k];
         sc_ff[k] <= ts_ff[k] * tc_ff[M+k];
         ss_ff[k] <= ts_ff[k] * ts_ff[M+k];
         cc_ff[k] <= tc_ff[k] * tc_ff[M+k];
         cs_ff[k] <= tc_ff[k] * ts_ff[M+k];
         ac_ff[k] <= $signed(link_ff[k][31:16]) * tc_ff[k];
         as_ff[k] <= $signed(link_ff[k][31:16]) * ts_ff[k];
      end
   end

   // link matrices, then a delay line so link k meets its chain slot
   always_ff @(posedge clock) begin
      for (int k = 0; k < M; k++) begin
         at_ff[0][k][0][0] <= ct_ff[k];
         at_ff[0][k][0][1] <= dhfk_pkg::clamp_rot(-dhfk_pkg::rnd14(48'(sc_ff[k])));
         at_ff[0][k][0][2] <= dhfk_pkg::clamp_rot(dhfk_pkg::rnd14(48'(ss_ff[k])));
         at_ff[0][k][1][0] <= st_ff[k];
         at_ff[0][k][1][1] <= dhfk_pkg::clamp_rot(dhfk_pkg::rnd14(48'(cc_ff[k])));
         at_ff[0][k][1][2] <= dhfk_pkg::clamp_rot(-dhfk_pkg::rnd14(48'(cs_ff[k])));
         at_ff[0][k][2][0] <= '0;
         at_ff[0][k][2][1] <= sa_ff[k];
         at_ff[0][k][2][2] <= ca_ff[k];
         tt_ff[0][k][0]    <= 17'(dhfk_pkg::rnd14(48'(ac_ff[k])));
         tt_ff[0][k][1]    <= 17'(dhfk_pkg::rnd14(48'(as_ff[k])));
      end
      for (int s = 1; s < dhfk_pkg::AT_DEPTH; s++) begin
         at_ff[s] <= at_ff[s-1];
         tt_ff[s] <= tt_ff[s-1];
      end
   end

   // chain inputs: identity and origin ahead of the first link
   always_comb begin
      for (int k = 0; k < M; k++) begin
         for (int r = 0; r < 3; r++) begin
            pin[k][r] = (k == 0) ? 24'sd0 : pp_ff[(k == 0) ? 0 : k-1][r];
            for (int c = 0; c < 3; c++) begin
               if (k == 0) rin[k][r][c] = (r == c) ? dhfk_pkg::ONE_Q14 : 16'sd0;
               else rin[k][r][c] = rr_ff[(k == 0) ? 0 : k-1][r][c];
            end
         end
         tv[k][0] = tt_ff[2*k][k][0];
         tv[k][1] = tt_ff[2*k][k][1];
         tv[k][2] = 17'($signed(link_ff[k][15:0]));
      end
   end

   // per link: multiply stage
   always_ff @(posedge clock) begin
      for (int k = 0; k < M; k++) begin
         for (int r = 0; r < 3; r++) begin
            pi_ff[k][r] <= pin[k][r];
            for (int j = 0; j < 3; j++) begin
               mp_ff[k][r][j] <= rin[k][r][j] * tv[k][j];
            end
            for (int c = 0; c < 3; c++) begin
               ri_ff[k][r][c] <= rin[k][r][c];
               for (int j = 0; j < 3; j++) begin
                  mr_ff[k][r][c][j] <= rin[k][r][j] * at_ff[2*k][k][j][c];
               end
            end
         end
      end
   end

   // per link: sum, round and clamp; unused links pass through
   always_ff @(posedge clock) begin
      for (int k = 0; k < M; k++) begin
         for (int r = 0; r < 3; r++) begin
            pp_ff[k][r] <= act[k] ?
               dhfk_pkg::sat_pos(48'(pi_ff[k][r]) + dhfk_pkg::rnd14(48'(mp_ff[k][r][0])
                  + 48'(mp_ff[k][r][1]) + 48'(mp_ff[k][r][2]))) : pi_ff[k][r];
            for (int c = 0; c < 3; c++) begin
               rr_ff[k][r][c] <= act[k] ?
                  dhfk_pkg::clamp_rot(dhfk_pkg::rnd14(48'(mr_ff[k][r][c][0])
                     + 48'(mr_ff[k][r][c][1]) + 48'(mr_ff[k][r][c][2])))
                  : ri_ff[k][r][c];
            end
         end
      end
   end

   // point transform: multiply, then sum and saturate into the output stage
   always_ff @(posedge clock) begin
      logic signed [15:0] pv [3];
      pv[0] = pt_ff[dhfk_pkg::PT_DEPTH-1].x;
      pv[1] = pt_ff[dhfk_pkg::PT_DEPTH-1].y;
      pv[2] = pt_ff[dhfk_pkg::PT_DEPTH-1].z;
      for (int r = 0; r < 3; r++) begin
         fp_ff[r] <= pp_ff[M-1][r];
         for (int j = 0; j < 3; j++) begin
            fm_ff[r][j] <= rr_ff[M-1][r][j] * pv[j];
            fr_ff[r][j] <= rr_ff[M-1][r][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         rot_ff[r] <= fr_ff[r];
         base_ff[r] <= dhfk_pkg::sat_pos(48'(fp_ff[r]) + dhfk_pkg::rnd14(48'(fm_ff[r][0])
            + 48'(fm_ff[r][1]) + 48'(fm_ff[r][2])));
      end
   end

   assign rsp_strobe = vld_ff[dhfk_pkg::LATENCY-1];
   assign rsp_rot_00 = rot_ff[0][0];
   assign rsp_rot_01 = rot_ff[0][1];
   assign rsp_rot_02 = rot_ff[0][2];
   assign rsp_rot_10 = rot_ff[1][0];
   assign rsp_rot_11 = rot_ff[1][1];
   assign rsp_rot_12 = rot_ff[1][2];
   assign rsp_rot_20 = rot_ff[2][0];
   assign rsp_rot_21 = rot_ff[2][1];
   assign rsp_rot_22 = rot_ff[2][2];
   assign rsp_base_x = base_ff[0];
   assign rsp_base_y = base_ff[1];
   assign rsp_base_z = base_ff[2];

   // every transfer in gives exactly one result at fixed latency
   `ASSERT_IMPLY(a_latency, clock, reset, start && !busy, ##(dhfk_pkg::LATENCY) rsp_strobe)
   `ASSERT_IMPLY(a_no_stray, clock, reset, rsp_strobe, $past(start, dhfk_pkg::LATENCY))
   // CORDIC lane 0 outputs and the first output rotation entry stay on the unit circle scale
   `ASSERT_IMPLY(a_cos_range, clock, reset, vld_ff[TS+1], (tc_ff[0] <= ONE) && (tc_ff[0] >= -ONE))
   `ASSERT_IMPLY(a_sin_range, clock, reset, vld_ff[TS+1], (ts_ff[0] <= ONE) && (ts_ff[0] >= -ONE))
   `ASSERT_IMPLY(a_rot_range, clock, reset, rsp_strobe, (rsp_rot_00 <= ONE) && (rsp_rot_00 >= -ONE))

endmodule
